// ===== design/bma_pkg.sv =====
// ----------------------------------------------------------------------------
// bma_pkg
// shared types and constants of the boxcar moving average block
// ----------------------------------------------------------------------------
package bma_pkg;

   localparam int         WIN_W     = 6;
   localparam logic [5:0] WIN_RESET = 6'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_UPDATE,
      ST_MDIV,
      ST_MWAIT,
      ST_EMIT,
      ST_SR_SETUP,
      ST_SR_CENTER,
      ST_SR_READ,
      ST_SR_ACC,
      ST_SR_DIV,
      ST_SR_WAIT,
      ST_SR_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SRC_SAMPLE,
      SRC_ZERO,
      SRC_QUOT
   } src_type;

   typedef enum logic [1:0] {
      CNT_ONE,
      CNT_WIN,
      CNT_HALF
   } cnt_type;

   typedef struct packed {
      logic    take_in;
      logic    ring_upd;
      logic    sum_upd;
      logic    end_run;
      logic    main_div;
      logic    emit_load;
      src_type emit_src;
      logic    emit_err;
      cnt_type emit_cnt;
      logic    out_load;
      logic    sr_setup;
      logic    sr_center;
      logic    sr_read;
      logic    sr_acc;
      logic    sr_div;
      logic    sr_out;
   } cmd_type;

   typedef struct packed {
      logic s_one;
      logic s_bad;
      logic s_even;
      logic k_lt_s;
      logic k_more;
      logic fin;
      logic cnt_one;
      logic rem_one;
      logic i_last;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

// ===== design/boxcar_moving_average_edge_hold.sv =====
// ----------------------------------------------------------------------------
// boxcar_moving_average_edge_hold
// centred running mean over an odd window with edge hold, Q15 samples
// ----------------------------------------------------------------------------
// req_* carries one sample a beat, tlast on the last sample of a run; rsp_*
// carries one result a beat, tlast on the last result of the run and tuser
// set on an error result (even or zero window, mean zero). csr_* writes the window,
// taken at the first sample of each run.
// Until the window has filled, a sample gives no result; after that, and for
// every result of a first full window, the running sum goes through the
// bit-serial divider, and a sample may also give extra edge-hold results.
// A run not longer than the window is replayed from the ring at its end:
// per result the window is centred, each windowed sample is read and
// summed, and the sum is divided and loaded as the result.
// The result register lets a new sample be taken while a result waits;
// a stalled receiver holds the sequencer at its next result.
// Reset clears the run state and the result register and sets the window
// to 5; ring contents need no clearing.
// ----------------------------------------------------------------------------
module boxcar_moving_average_edge_hold import bma_pkg::*; #(
   parameter int MAX_WINDOW  = 63,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,  // sample_in
   input  logic                                   req_tlast,  // final_sample
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [WIN_W-1:0]                       csr_data,   // window_size
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] rsp_tdata,  // mean_out
   output logic                                   rsp_tlast,  // end_of_run
   output logic                                   rsp_tuser   // window_error
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   bma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bma_datapath #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ===== design/bma_ram.sv =====
// ----------------------------------------------------------------------------
// bma_ram
// generic simple dual-port ram, one write and one registered read
// ----------------------------------------------------------------------------
module bma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/bma_div.sv =====
// ----------------------------------------------------------------------------
// bma_div
// bit-serial signed divider, rounds to nearest, one quotient bit a cycle
// ----------------------------------------------------------------------------
module bma_div #(
   parameter int DVD_W = 22,
   parameter int DVR_W = 6,
   parameter int Q_W   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DVD_W-1:0] dividend,
   input  logic [DVR_W-1:0]        divisor,
   output logic                    done,
   output logic [Q_W-1:0]          quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, done_ff, neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] dvd_ff;
   logic [DVR_W:0]   rem_ff;
   logic [DVR_W-1:0] dvr_ff;
   logic [DVD_W-1:0] mag, mag_rnd;
   logic [DVR_W:0]   rem_sh;
   logic             ge;
   logic [Q_W-1:0]   q_mag;

   always_comb begin
      mag     = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
      mag_rnd = mag + DVD_W'(divisor >> 1);
      rem_sh  = {rem_ff[DVR_W-1:0], dvd_ff[DVD_W-1]};
      ge      = rem_sh >= {1'b0, dvr_ff};
      q_mag   = dvd_ff[Q_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
            dvd_ff  <= mag_rnd;
            rem_ff  <= '0;
            dvr_ff  <= divisor;
            neg_ff  <= dividend[DVD_W-1];
         end else if (busy_ff) begin
            dvd_ff <= {dvd_ff[DVD_W-2:0], ge};
            rem_ff <= ge ? rem_sh - {1'b0, dvr_ff} : rem_sh;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -q_mag : q_mag;

endmodule

// ===== design/bma_datapath.sv =====
// ----------------------------------------------------------------------------
// bma_datapath
// sample ring, running sum, short-run window sums, divider and output register
// ----------------------------------------------------------------------------
module bma_datapath import bma_pkg::*; #(
   parameter int MAX_WINDOW  = 63,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,
   input  logic                                   req_tlast,
   input  logic                                   csr_valid,
   input  logic [WIN_W-1:0]                       csr_data,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tuser,
   input  cmd_type                                cmd,
   output sts_type                                sts
);

   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int DEPTH  = MAX_WINDOW + 1;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int SUM_W  = SAMPLE_BITS + PTR_W;

   logic [WIN_W-1:0]       win_ff, run_ff, seen_ff, rem_ff;
   logic [WIN_W-1:0]       n_ff, sp_ff, e_ff, i_ff, cnt_ff;
   logic [PTR_W-1:0]       wp_ff, j_ff;
   logic [SAMPLE_BITS-1:0] x_ff, val_ff, out_data_ff;
   logic                   fin_ff, first_ff, err_ff;
   logic                   out_valid_ff, out_last_ff, out_err_ff;
   logic signed [SUM_W-1:0] sum_ff, acc_ff;

   logic [SAMPLE_BITS-1:0] rdata, quot;
   logic [PTR_W-1:0]       raddr, wp_next;
   logic [PTR_W:0]         old_tmp;
   logic [WIN_W-1:0]       e_main, sp_c, c_hi, c_sel, rem_in;
   logic signed [SUM_W-1:0] x_ext, r_ext, sum_in, dvd;
   logic                   div_done;

   always_comb begin
      x_ext   = {{(SUM_W - SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff};
      r_ext   = {{(SUM_W - SAMPLE_BITS){rdata[SAMPLE_BITS-1]}}, rdata};
      sum_in  = sts.k_lt_s ? sum_ff + x_ext : sum_ff + x_ext - r_ext;
      old_tmp = {1'b0, wp_ff} + (PTR_W + 1)'(DEPTH) - (PTR_W + 1)'(run_ff);
      if (old_tmp >= (PTR_W + 1)'(DEPTH)) begin
         old_tmp = old_tmp - (PTR_W + 1)'(DEPTH);
      end
      wp_next = (wp_ff == PTR_W'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      raddr   = cmd.sr_read ? j_ff : old_tmp[PTR_W-1:0];
      e_main  = (run_ff - 1'b1) >> 1;
      if (seen_ff < WIN_W'(4)) begin
         sp_c = WIN_W'(1);
      end else if (seen_ff[0]) begin
         sp_c = seen_ff - WIN_W'(2);
      end else begin
         sp_c = seen_ff - WIN_W'(1);
      end
      c_hi = n_ff - 1'b1 - e_ff;
      if (i_ff < e_ff) begin
         c_sel = e_ff;
      end else if (i_ff > c_hi) begin
         c_sel = c_hi;
      end else begin
         c_sel = i_ff;
      end
      case (cmd.emit_cnt)
         CNT_WIN:  rem_in = run_ff;
         CNT_HALF: rem_in = (first_ff || fin_ff) ? e_main + 1'b1 : WIN_W'(1);
         default:  rem_in = WIN_W'(1);
      endcase
      dvd = cmd.sr_div ? acc_ff : sum_ff;
   end

   always_comb begin
      sts.s_one    = run_ff == WIN_W'(1);
      sts.s_bad    = (run_ff == '0) || (32'(run_ff) > MAX_WINDOW);
      sts.s_even   = ~run_ff[0];
      sts.k_lt_s   = seen_ff < run_ff;
      sts.k_more   = ({1'b0, seen_ff} + 1'b1) < {1'b0, run_ff};
      sts.fin      = fin_ff;
      sts.cnt_one  = cnt_ff == WIN_W'(1);
      sts.rem_one  = rem_ff == WIN_W'(1);
      sts.i_last   = i_ff == n_ff - 1'b1;
      sts.div_done = div_done;
      sts.out_free = ~out_valid_ff | rsp_tready;
   end

   bma_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ring (
      .clock (clock),
      .we    (cmd.ring_upd),
      .waddr (wp_ff),
      .wdata (x_ff),
      .raddr (raddr),
      .rdata (rdata)
   );

   bma_div #(.DVD_W(SUM_W), .DVR_W(WIN_W), .Q_W(SAMPLE_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.main_div | cmd.sr_div),
      .dividend (dvd),
      .divisor  (cmd.sr_div ? sp_ff : run_ff),
      .done     (div_done),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= WIN_RESET;
         run_ff       <= WIN_RESET;
         seen_ff      <= '0;
         sum_ff       <= '0;
         wp_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            win_ff <= csr_data;
         end
         if (cmd.take_in && seen_ff == '0) begin
            run_ff <= win_ff;
         end
         if (cmd.end_run) begin
            seen_ff <= '0;
            sum_ff  <= '0;
            wp_ff   <= '0;
         end else if (cmd.sum_upd) begin
            sum_ff <= sum_in;
            wp_ff  <= wp_next;
            if (sts.k_lt_s) begin
               seen_ff <= seen_ff + 1'b1;
            end
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_in) begin
         x_ff   <= req_tdata[SAMPLE_BITS-1:0];
         fin_ff <= req_tlast;
      end
      if (cmd.sum_upd) begin
         first_ff <= ({1'b0, seen_ff} + 1'b1) == {1'b0, run_ff};
      end
      if (cmd.emit_load) begin
         case (cmd.emit_src)
            SRC_SAMPLE: val_ff <= x_ff;
            SRC_QUOT:   val_ff <= quot;
            default:    val_ff <= '0;
         endcase
         err_ff <= cmd.emit_err;
         rem_ff <= rem_in;
      end else if (cmd.out_load && !cmd.sr_out) begin
         rem_ff <= rem_ff - 1'b1;
      end
      if (cmd.sr_setup) begin
         n_ff  <= seen_ff;
         sp_ff <= sp_c;
         e_ff  <= (sp_c - 1'b1) >> 1;
         i_ff  <= '0;
      end
      if (cmd.sr_center) begin
         j_ff   <= PTR_W'(c_sel - e_ff);
         cnt_ff <= sp_ff;
         acc_ff <= '0;
      end
      if (cmd.sr_acc) begin
         acc_ff <= acc_ff + r_ext;
         j_ff   <= j_ff + 1'b1;
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.out_load) begin
         if (cmd.sr_out) begin
            out_data_ff <= quot;
            out_last_ff <= sts.i_last;
            out_err_ff  <= 1'b0;
            i_ff        <= i_ff + 1'b1;
         end else begin
            out_data_ff <= val_ff;
            out_last_ff <= fin_ff & sts.rem_one;
            out_err_ff  <= err_ff;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DATA_W'(out_data_ff);
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

endmodule

// ===== design/bma_ctrl.sv =====
// ----------------------------------------------------------------------------
// bma_ctrl
// sequencer for sample update, edge hold replay and short-run fallback
// ----------------------------------------------------------------------------
module bma_ctrl import bma_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.s_one || sts.s_bad) state_in = ST_EMIT;
            else                        state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (sts.k_lt_s && sts.fin) state_in = ST_SR_SETUP;
            else if (sts.k_more)       state_in = ST_IDLE;
            else if (sts.s_even)       state_in = ST_EMIT;
            else                       state_in = ST_MDIV;
         end
         ST_MDIV:  state_in = ST_MWAIT;
         ST_MWAIT: begin
            if (sts.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free && sts.rem_one) state_in = ST_IDLE;
         end
         ST_SR_SETUP:  state_in = ST_SR_CENTER;
         ST_SR_CENTER: state_in = ST_SR_READ;
         ST_SR_READ:   state_in = ST_SR_ACC;
         ST_SR_ACC: begin
            if (sts.cnt_one) state_in = ST_SR_DIV;
            else             state_in = ST_SR_READ;
         end
         ST_SR_DIV:  state_in = ST_SR_WAIT;
         ST_SR_WAIT: begin
            if (sts.div_done) state_in = ST_SR_EMIT;
         end
         ST_SR_EMIT: begin
            if (sts.out_free) state_in = sts.i_last ? ST_IDLE : ST_SR_CENTER;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: cmd.take_in = req_tvalid;
         ST_CHECK: begin
            if (sts.s_one || sts.s_bad) begin
               cmd.emit_load = 1'b1;
               cmd.emit_src  = sts.s_one ? SRC_SAMPLE : SRC_ZERO;
               cmd.emit_err  = ~sts.s_one;
               cmd.emit_cnt  = CNT_ONE;
            end else begin
               cmd.ring_upd = 1'b1;
            end
         end
         ST_UPDATE: begin
            cmd.sum_upd = 1'b1;
            if (!(sts.k_lt_s && sts.fin) && !sts.k_more && sts.s_even) begin
               cmd.emit_load = 1'b1;
               cmd.emit_src  = SRC_ZERO;
               cmd.emit_err  = 1'b1;
               cmd.emit_cnt  = sts.k_lt_s ? CNT_WIN : CNT_ONE;
            end
         end
         ST_MDIV: cmd.main_div = 1'b1;
         ST_MWAIT: begin
            if (sts.div_done) begin
               cmd.emit_load = 1'b1;
               cmd.emit_src  = SRC_QUOT;
               cmd.emit_cnt  = CNT_HALF;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.end_run  = sts.rem_one & sts.fin;
            end
         end
         ST_SR_SETUP:  cmd.sr_setup  = 1'b1;
         ST_SR_CENTER: cmd.sr_center = 1'b1;
         ST_SR_READ:   cmd.sr_read   = 1'b1;
         ST_SR_ACC:    cmd.sr_acc    = 1'b1;
         ST_SR_DIV:    cmd.sr_div    = 1'b1;
         ST_SR_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.sr_out   = 1'b1;
               cmd.end_run  = sts.i_last;
            end
         end
         default: cmd = '0;
      endcase
   end

   assign req_tready = state_ff == ST_IDLE;

endmodule

// ===== design/bma_checker.sv =====
// ----------------------------------------------------------------------------
// bma_checker
// port-level checks of the boxcar moving average block
// ----------------------------------------------------------------------------
module bma_checker #(
   parameter int DATA_W = 16
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped under stall");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("error beat with non-zero mean");

   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_reset_in: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

endmodule

bind boxcar_moving_average_edge_hold bma_checker #(
   .DATA_W(((SAMPLE_BITS + 7) / 8) * 8)
) u_bma_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
